// ===== rtl/gtb_pkg.sv =====
package gtb_pkg;

    localparam int DEF_MAX_COLUMNS  = 64;
    localparam int DEF_MAX_ROWS     = 64;
    localparam int DEF_COUNTER_BITS = 32;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_TILE_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_TILE_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TILES_ACROSS    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TILES_DOWN      = 3'd5;

    localparam logic REQ_BOX  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] box_left;
        logic signed [31:0] box_bottom;
        logic signed [31:0] box_right;
        logic signed [31:0] box_top;
        logic        [5:0]  read_column;
        logic        [5:0]  read_row;
    } req_t;

    typedef struct packed {
        logic [31:0] tile_count;
        logic        count_saturated;
    } resp_t;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic        [31:0] inv_tile_width;
        logic        [31:0] inv_tile_height;
        logic        [6:0]  tiles_across;
        logic        [6:0]  tiles_down;
    } cfg_t;

endpackage

// ===== rtl/gtb_ram.sv =====
module gtb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/gtb_front.sv =====
module gtb_front #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64,
    parameter int CIW         = 6,
    parameter int RIW         = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gtb_pkg::cfg_t                cfg,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  gtb_pkg::req_t                req,
    output logic                         push,
    input  logic                         push_ready,
    output logic [1+1+2*CIW+2*RIW-1:0]   entry
);

    import gtb_pkg::*;

    localparam int CCW = $clog2(MAX_COLUMNS + 1);
    localparam int RCW = $clog2(MAX_ROWS + 1);

    typedef struct packed {
        logic           is_read;
        logic           oob;
        logic [CIW-1:0] c0;
        logic [CIW-1:0] c1;
        logic [RIW-1:0] r0;
        logic [RIW-1:0] r1;
    } entry_t;

    req_t           item_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [2:0]     step_reg;
    logic           d_vld_reg;
    logic [1:0]     d_sel_reg;
    logic [31:0]    diff_reg;
    logic           d_pos_reg;
    logic           p_vld_reg;
    logic [1:0]     p_sel_reg;
    logic [63:0]    prod_reg;
    logic           p_pos_reg;
    logic [CIW-1:0] c0_reg;
    logic [CIW-1:0] c1_reg;
    logic [RIW-1:0] r0_reg;
    logic [RIW-1:0] r1_reg;

    logic [CCW-1:0]     cols;
    logic [RCW-1:0]     rows;
    logic [CIW-1:0]     col_lim;
    logic [RIW-1:0]     row_lim;
    logic               accept;
    logic               is_read;
    logic               reversed;
    logic               issue;
    logic signed [31:0] coord;
    logic signed [31:0] org;
    logic signed [32:0] diff_w;
    logic [31:0]        inv;
    logic [47:0]        hi;
    logic [CIW-1:0]     col_clamp;
    logic [RIW-1:0]     row_clamp;
    logic               rd_oob;
    entry_t             entry_w;

    always_comb
    begin
        if (cfg.tiles_across == '0)
            cols = CCW'(1);
        else if (32'(cfg.tiles_across) > 32'(MAX_COLUMNS))
            cols = CCW'(MAX_COLUMNS);
        else
            cols = CCW'(cfg.tiles_across);
        if (cfg.tiles_down == '0)
            rows = RCW'(1);
        else if (32'(cfg.tiles_down) > 32'(MAX_ROWS))
            rows = RCW'(MAX_ROWS);
        else
            rows = RCW'(cfg.tiles_down);
    end

    assign col_lim = CIW'(cols - CCW'(1));
    assign row_lim = RIW'(rows - RCW'(1));

    assign req_ready = !busy_reg;
    assign accept    = req_valid && req_ready;
    assign is_read   = (item_reg.req_type == REQ_READ);
    assign reversed  = (item_reg.box_right < item_reg.box_left) ||
                       (item_reg.box_top < item_reg.box_bottom);
    assign issue     = busy_reg && !is_read && !reversed && (step_reg < 3'd4);

    always_comb
    begin
        unique case (step_reg[1:0])
            2'd0: coord = item_reg.box_left;
            2'd1: coord = item_reg.box_right;
            2'd2: coord = item_reg.box_bottom;
            2'd3: coord = item_reg.box_top;
        endcase
    end

    assign org    = step_reg[1] ? cfg.origin_y : cfg.origin_x;
    assign diff_w = {coord[31], coord} - {org[31], org};
    assign inv    = d_sel_reg[1] ? cfg.inv_tile_height : cfg.inv_tile_width;
    assign hi     = prod_reg[63:16];

    always_comb
    begin
        if (!p_pos_reg)
            col_clamp = '0;
        else if (hi > 48'(col_lim))
            col_clamp = col_lim;
        else
            col_clamp = hi[CIW-1:0];
        if (!p_pos_reg)
            row_clamp = '0;
        else if (hi > 48'(row_lim))
            row_clamp = row_lim;
        else
            row_clamp = hi[RIW-1:0];
    end

    assign rd_oob = (32'(item_reg.read_column) >= 32'(cols)) ||
                    (32'(item_reg.read_row) >= 32'(rows));

    always_comb
    begin
        entry_w.is_read = is_read;
        entry_w.oob     = is_read && rd_oob;
        entry_w.c0      = is_read ? CIW'(item_reg.read_column) : c0_reg;
        entry_w.c1      = c1_reg;
        entry_w.r0      = is_read ? RIW'(item_reg.read_row) : r0_reg;
        entry_w.r1      = r1_reg;
    end

    assign push  = busy_reg && (is_read || done_reg);
    assign entry = entry_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            step_reg  <= '0;
            d_vld_reg <= 1'b0;
            p_vld_reg <= 1'b0;
        end
        else
        begin
            d_vld_reg <= issue;
            p_vld_reg <= d_vld_reg;
            if (accept)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (push && push_ready)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b0;
            end
            else if (busy_reg && !is_read && reversed)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                if (issue)
                    step_reg <= step_reg + 3'd1;
                if (p_vld_reg && (p_sel_reg == 2'd3))
                    done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= req;
        if (issue)
        begin
            diff_reg  <= diff_w[31:0];
            d_pos_reg <= !diff_w[32] && (diff_w != '0);
            d_sel_reg <= step_reg[1:0];
        end
        if (d_vld_reg)
        begin
            prod_reg  <= 64'(diff_reg) * 64'(inv);
            p_pos_reg <= d_pos_reg;
            p_sel_reg <= d_sel_reg;
        end
        if (p_vld_reg)
        begin
            unique case (p_sel_reg)
                2'd0: c0_reg <= col_clamp;
                2'd1: c1_reg <= col_clamp;
                2'd2: r0_reg <= row_clamp;
                2'd3: r1_reg <= row_clamp;
            endcase
        end
    end

endmodule

// ===== rtl/gtb_queue.sv =====
module gtb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/gtb_back.sv =====
module gtb_back #(
    parameter int MAX_COLUMNS  = 64,
    parameter int MAX_ROWS     = 64,
    parameter int COUNTER_BITS = 32,
    parameter int CIW          = 6,
    parameter int RIW          = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    output logic                       q_pop,
    input  logic [1+1+2*CIW+2*RIW-1:0] q_data,
    output logic                       clearing,
    output logic                       resp_valid,
    input  logic                       resp_ready,
    output gtb_pkg::resp_t             resp
);

    import gtb_pkg::*;

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_WR    = 3'd3;
    localparam logic [2:0] S_RREQ  = 3'd4;
    localparam logic [2:0] S_ROUT  = 3'd5;

    typedef struct packed {
        logic           is_read;
        logic           oob;
        logic [CIW-1:0] c0;
        logic [CIW-1:0] c1;
        logic [RIW-1:0] r0;
        logic [RIW-1:0] r1;
    } entry_t;

    logic [2:0]     state_reg;
    logic [2:0]     state_next;
    logic [AW-1:0]  clr_reg;
    entry_t         cmd_reg;
    logic [CIW-1:0] col_reg;
    logic [RIW-1:0] row_reg;
    logic           resp_valid_reg;
    resp_t          resp_reg;

    entry_t                  head;
    logic [AW-1:0]           addr;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [COUNTER_BITS-1:0] ram_wdata;
    logic                    ram_re;
    logic [COUNTER_BITS-1:0] ram_rdata;
    logic [COUNTER_BITS-1:0] bumped;
    logic [63:0]             wide;
    logic                    full_cnt;
    logic                    out_free;
    logic                    row_last;
    logic                    col_last;

    assign head     = entry_t'(q_data);
    assign addr     = AW'(AW'(col_reg) * AW'(MAX_ROWS) + AW'(row_reg));
    assign full_cnt = (ram_rdata == '1);
    assign bumped   = full_cnt ? ram_rdata : ram_rdata + COUNTER_BITS'(1);
    assign wide     = 64'(ram_rdata);
    assign out_free = !resp_valid_reg || resp_ready;
    assign row_last = (row_reg == cmd_reg.r1);
    assign col_last = (col_reg == cmd_reg.c1);

    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign clearing  = (state_reg == S_CLEAR);
    assign ram_we    = (state_reg == S_CLEAR) || (state_reg == S_WR);
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_reg : addr;
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 : bumped;
    assign ram_re    = (state_reg == S_RD) || (state_reg == S_RREQ);

    gtb_ram #(
        .WIDTH (COUNTER_BITS),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (!head.is_read)
                        state_next = S_RD;
                    else if (head.oob)
                        state_next = S_ROUT;
                    else
                        state_next = S_RREQ;
                end
            end
            S_RD:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                state_next = (row_last && col_last) ? S_IDLE : S_RD;
            end
            S_RREQ:
            begin
                state_next = S_ROUT;
            end
            S_ROUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + AW'(1);
            if ((state_reg == S_ROUT) && out_free)
                resp_valid_reg <= 1'b1;
            else if (resp_ready)
                resp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= head;
            col_reg <= head.c0;
            row_reg <= head.r0;
        end
        else if (state_reg == S_WR)
        begin
            if (row_last)
            begin
                row_reg <= cmd_reg.r0;
                col_reg <= col_reg + CIW'(1);
            end
            else
            begin
                row_reg <= row_reg + RIW'(1);
            end
        end
        if ((state_reg == S_ROUT) && out_free)
        begin
            resp_reg.tile_count      <= cmd_reg.oob ? '0 : wide[31:0];
            resp_reg.count_saturated <= !cmd_reg.oob && full_cnt;
        end
    end

    assign resp_valid = resp_valid_reg;
    assign resp       = resp_reg;

endmodule

// ===== rtl/grid_tile_box_coverage_counter_unit.sv =====
// Grid tile box coverage counter.
// Request channel (req_valid/req_ready/req): req_type selects a box request,
// which adds one (saturating) to every tile that the box covers, or a read request, which
// returns one tile counter on the response channel (resp_valid/resp_ready).
// Box requests give no response. The user writes configuration through
// cfg_we, cfg_index and cfg_data while the unit is idle; the unit itself
// does not enforce this. The front end takes one request at a time; for a
// box, one shared 32x32 multiplier maps the four box edges in turn.
// Requests then wait in a two-entry queue for the walker, which visits each
// covered tile on the counter memory (read, then write back). The front end
// can take a new request while the walker still works on an earlier one, as
// long as the queue has room. Throughput is set by the slower side.
// Reset: config registers take their defaults, then the counter memory is
// cleared one entry per cycle (MAX_COLUMNS*MAX_ROWS entries, 4096 by
// default); req_ready stays low until that is done.
// A stalled response holds in the output register; the walker stops at the
// next read, the queue fills and req_ready drops.
module grid_tile_box_coverage_counter_unit #(
    parameter int MAX_COLUMNS  = gtb_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS     = gtb_pkg::DEF_MAX_ROWS,
    parameter int COUNTER_BITS = gtb_pkg::DEF_COUNTER_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [gtb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [gtb_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  gtb_pkg::req_t                    req,
    output logic                             resp_valid,
    input  logic                             resp_ready,
    output gtb_pkg::resp_t                   resp
);

    import gtb_pkg::*;

    localparam int CIW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int EW  = 1 + 1 + 2 * CIW + 2 * RIW;

    cfg_t          cfg_reg;
    logic          clearing;
    logic          front_ready;
    logic          q_push;
    logic          q_ready;
    logic [EW-1:0] q_in;
    logic          q_valid;
    logic          q_pop;
    logic [EW-1:0] q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x        <= '0;
            cfg_reg.origin_y        <= '0;
            cfg_reg.inv_tile_width  <= 32'd65536;
            cfg_reg.inv_tile_height <= 32'd65536;
            cfg_reg.tiles_across    <= 7'd64;
            cfg_reg.tiles_down      <= 7'd64;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X:        cfg_reg.origin_x        <= cfg_data;
                REG_ORIGIN_Y:        cfg_reg.origin_y        <= cfg_data;
                REG_INV_TILE_WIDTH:  cfg_reg.inv_tile_width  <= cfg_data;
                REG_INV_TILE_HEIGHT: cfg_reg.inv_tile_height <= cfg_data;
                REG_TILES_ACROSS:    cfg_reg.tiles_across    <= cfg_data[6:0];
                REG_TILES_DOWN:      cfg_reg.tiles_down      <= cfg_data[6:0];
                default:             ;
            endcase
        end
    end

    assign req_ready = front_ready && !clearing;

    gtb_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .CIW         (CIW),
        .RIW         (RIW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .req_valid  (req_valid && !clearing),
        .req_ready  (front_ready),
        .req        (req),
        .push       (q_push),
        .push_ready (q_ready),
        .entry      (q_in)
    );

    gtb_queue #(
        .WIDTH (EW),
        .DEPTH (2)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_ready (q_ready),
        .push_data  (q_in),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_out)
    );

    gtb_back #(
        .MAX_COLUMNS  (MAX_COLUMNS),
        .MAX_ROWS     (MAX_ROWS),
        .COUNTER_BITS (COUNTER_BITS),
        .CIW          (CIW),
        .RIW          (RIW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_data     (q_out),
        .clearing   (clearing),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .resp       (resp)
    );

    a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_valid && req_ready && clearing))
        else $error("request accepted during memory clear");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && !q_ready |=> q_push)
        else $error("queue entry dropped while queue full");

    a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !q_pop)
        else $error("walker took a request during memory clear");

endmodule
